/* src/rrbm_pkg.sv */
// rrbm_pkg: shared widths, codes and controller/datapath link types of the bank mapper
package rrbm_pkg;

  localparam int unsigned OpW       = 1;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned TargetW   = 3;
  localparam int unsigned PhysW     = 21;
  localparam int unsigned RomCountW = 8;
  localparam int unsigned RamCountW = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam int unsigned BankLowW  = 5;
  localparam int unsigned BankHighW = 2;
  localparam int unsigned BankW     = BankLowW + BankHighW;
  localparam int unsigned RemCntW   = $clog2(BankW);

  // offsets inside a 16 KiB rom bank and an 8 KiB ram bank
  localparam int unsigned RomOffW   = 14;
  localparam int unsigned RamOffW   = 13;

  localparam logic [RomCountW-1:0] RomCountReset = 8'd2;
  localparam logic [RamCountW-1:0] RamCountReset = 3'd1;
  localparam logic [BankLowW-1:0]  BankLowReset  = 5'd1;

  localparam logic [3:0]       RamEnableKey = 4'hA;
  localparam logic [ByteW-1:0] ModeRomByte  = 8'h00;
  localparam logic [ByteW-1:0] ModeRamByte  = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROM_BANK_COUNT = 2'd0,
    REG_RAM_BANK_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [TargetW-1:0] {
    TGT_ROM_READ  = 3'd0,
    TGT_RAM_READ  = 3'd1,
    TGT_RAM_WRITE = 3'd2,
    TGT_OPEN_BUS  = 3'd3,
    TGT_REG_WRITE = 3'd4,
    TGT_UNMAPPED  = 3'd5
  } target_e;

  // register write windows, from address bits 14:13
  typedef enum logic [1:0] {
    WIN_RAM_ENABLE = 2'b00,
    WIN_BANK_LOW   = 2'b01,
    WIN_BANK_HIGH  = 2'b10,
    WIN_MODE       = 2'b11
  } reg_win_e;

  typedef struct packed {
    logic latch_item;
    logic div_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_banked;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/rrbm_if.sv */
// rrbm_if: handshake channels of the bank mapper (bus access, result, configuration)
interface rrbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrbm_pkg::OpW-1:0]    operation;
  logic [rrbm_pkg::AddrW-1:0]  bus_address;
  logic [rrbm_pkg::ByteW-1:0]  write_byte;

  modport source (output valid, output operation, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input operation, input bus_address, input write_byte,
                  output ready);
endinterface

interface rrbm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrbm_pkg::TargetW-1:0] target;
  logic [rrbm_pkg::PhysW-1:0]   physical_address;
  logic [rrbm_pkg::ByteW-1:0]   ram_write_data;

  modport source (output valid, output target, output physical_address,
                  output ram_write_data, input ready);
  modport sink   (input valid, input target, input physical_address,
                  input ram_write_data, output ready);
endinterface

interface rrbm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rrbm_pkg::CfgIdxW-1:0]  index;
  logic [rrbm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/rrbm_rem.sv */
// rrbm_rem: restoring remainder unit, one quotient bit per cycle, for the rom bank wrap
module rrbm_rem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rrbm_pkg::BankW-1:0]     dividend_i,
  input  logic [rrbm_pkg::RomCountW-1:0] divisor_i,
  output logic                           busy_o,
  output logic [rrbm_pkg::BankW-1:0]     rem_o
);

  logic                           busy_q, busy_d;
  logic [rrbm_pkg::RemCntW-1:0]   cnt_q, cnt_d;
  logic [rrbm_pkg::RomCountW-1:0] rem_q, rem_d;
  logic [rrbm_pkg::BankW-1:0]     dvd_q;
  logic [rrbm_pkg::RomCountW-1:0] div_q;
  logic [rrbm_pkg::RomCountW:0]   trial;

  // partial remainder stays below the divisor, so the trial fits one extra bit
  always_comb begin
    trial = {rem_q, dvd_q[rrbm_pkg::BankW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = rrbm_pkg::RomCountW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[rrbm_pkg::RomCountW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rrbm_pkg::RemCntW'(rrbm_pkg::BankW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      // a zero count behaves as a single bank
      div_q <= (divisor_i == '0) ? rrbm_pkg::RomCountW'(1) : divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[rrbm_pkg::BankW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  // remainder never exceeds the 7-bit dividend
  assign rem_o  = rem_q[rrbm_pkg::BankW-1:0];

endmodule

/* src/rrbm_dp.sv */
// rrbm_dp: banking registers, configuration, address mapping and result register
module rrbm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrbm_pkg::dp_cmd_t              cmd_i,
  output rrbm_pkg::dp_sts_t              sts_o,
  input  logic                           cfg_valid_i,
  input  logic [rrbm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrbm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [rrbm_pkg::OpW-1:0]       in_operation_i,
  input  logic [rrbm_pkg::AddrW-1:0]     in_bus_address_i,
  input  logic [rrbm_pkg::ByteW-1:0]     in_write_byte_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [rrbm_pkg::TargetW-1:0]   out_target_o,
  output logic [rrbm_pkg::PhysW-1:0]     out_physical_address_o,
  output logic [rrbm_pkg::ByteW-1:0]     out_ram_write_data_o
);

  logic [rrbm_pkg::RomCountW-1:0] rom_cnt_q;
  logic [rrbm_pkg::RamCountW-1:0] ram_cnt_q;
  logic                           ram_en_q;
  logic [rrbm_pkg::BankLowW-1:0]  bank_low_q;
  logic [rrbm_pkg::BankHighW-1:0] bank_high_q;
  logic                           mode_q;

  logic [rrbm_pkg::OpW-1:0]       op_q;
  logic [rrbm_pkg::AddrW-1:0]     addr_q;
  logic [rrbm_pkg::ByteW-1:0]     byte_q;

  logic                           out_valid_q;
  rrbm_pkg::target_e              out_target_q;
  logic [rrbm_pkg::PhysW-1:0]     out_phys_q;
  logic [rrbm_pkg::ByteW-1:0]     out_wdata_q;

  logic [rrbm_pkg::BankW-1:0]     rom_sel_raw;
  logic [rrbm_pkg::BankW-1:0]     rom_sel;
  logic [rrbm_pkg::BankW-1:0]     rom_sel_wrapped;
  logic                           div_busy;
  logic [rrbm_pkg::BankHighW-1:0] ram_sel;
  logic                           ram_win;
  logic                           is_write;
  rrbm_pkg::target_e              res_target;
  logic [rrbm_pkg::PhysW-1:0]     res_phys;
  logic [rrbm_pkg::ByteW-1:0]     res_wdata;

  // bank selection, banks with all-zero low bits move up by one
  always_comb begin
    if (!mode_q) begin
      rom_sel_raw = {bank_high_q, bank_low_q};
    end else begin
      rom_sel_raw = {{rrbm_pkg::BankHighW{1'b0}}, bank_low_q};
    end
    rom_sel = (bank_low_q == '0) ? rom_sel_raw + 1'b1 : rom_sel_raw;
  end

  assign ram_sel = (!mode_q || ram_cnt_q <= rrbm_pkg::RamCountW'(1)) ? '0 : bank_high_q;

  rrbm_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rom_sel),
    .divisor_i  (rom_cnt_q),
    .busy_o     (div_busy),
    .rem_o      (rom_sel_wrapped)
  );

  assign sts_o.in_banked = (in_operation_i == 1'b0) && (in_bus_address_i[15:14] == 2'b01);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign ram_win  = (addr_q[15:13] == 3'b101);
  assign is_write = op_q[0];

  always_comb begin
    res_target = rrbm_pkg::TGT_UNMAPPED;
    res_phys   = '0;
    res_wdata  = '0;
    if (ram_win) begin
      if (!ram_en_q) begin
        res_target = is_write ? rrbm_pkg::TGT_REG_WRITE : rrbm_pkg::TGT_OPEN_BUS;
      end else begin
        res_target = is_write ? rrbm_pkg::TGT_RAM_WRITE : rrbm_pkg::TGT_RAM_READ;
        res_phys   = rrbm_pkg::PhysW'({ram_sel, addr_q[rrbm_pkg::RamOffW-1:0]});
        res_wdata  = is_write ? byte_q : '0;
      end
    end else if (!addr_q[15]) begin
      if (is_write) begin
        res_target = rrbm_pkg::TGT_REG_WRITE;
      end else begin
        res_target = rrbm_pkg::TGT_ROM_READ;
        if (addr_q[14]) begin
          res_phys = {rom_sel_wrapped, addr_q[rrbm_pkg::RomOffW-1:0]};
        end else begin
          res_phys = rrbm_pkg::PhysW'(addr_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_cnt_q <= rrbm_pkg::RomCountReset;
      ram_cnt_q <= rrbm_pkg::RamCountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rrbm_pkg::REG_ROM_BANK_COUNT: rom_cnt_q <= cfg_data_i;
        rrbm_pkg::REG_RAM_BANK_COUNT: ram_cnt_q <= cfg_data_i[rrbm_pkg::RamCountW-1:0];
        default: ;
      endcase
    end
  end

  // register writes take effect when their word is handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q    <= 1'b0;
      bank_low_q  <= rrbm_pkg::BankLowReset;
      bank_high_q <= '0;
      mode_q      <= 1'b0;
    end else if (cmd_i.load_out && is_write && !addr_q[15]) begin
      unique case (rrbm_pkg::reg_win_e'(addr_q[14:13]))
        rrbm_pkg::WIN_RAM_ENABLE: ram_en_q    <= (byte_q[3:0] == rrbm_pkg::RamEnableKey);
        rrbm_pkg::WIN_BANK_LOW:   bank_low_q  <= byte_q[rrbm_pkg::BankLowW-1:0];
        rrbm_pkg::WIN_BANK_HIGH:  bank_high_q <= byte_q[rrbm_pkg::BankHighW-1:0];
        rrbm_pkg::WIN_MODE: begin
          if (byte_q == rrbm_pkg::ModeRomByte) begin
            mode_q <= 1'b0;
          end else if (byte_q == rrbm_pkg::ModeRamByte) begin
            mode_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q   <= in_operation_i;
      addr_q <= in_bus_address_i;
      byte_q <= in_write_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_target_q <= res_target;
      out_phys_q   <= res_phys;
      out_wdata_q  <= res_wdata;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_target_o           = out_target_q;
  assign out_physical_address_o = out_phys_q;
  assign out_ram_write_data_o   = out_wdata_q;

endmodule

/* src/rrbm_ctrl.sv */
// rrbm_ctrl: sequencing of one bus access through bank wrap and result hand-off
module rrbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrbm_pkg::dp_sts_t sts_i,
  output rrbm_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    cmd_o.latch_item = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_item = 1'b1;
          // only switchable rom reads need the bank wrap
          if (sts_i.in_banked) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/rom_ram_bank_mapper.sv */
// rom_ram_bank_mapper: cartridge bank controller top level
//
//  channel  dir  handshake    word
//  cfg_i    in   valid/ready  index, data (bank counts)
//  in_i     in   valid/ready  operation, bus_address, write_byte
//  out_o    out  valid/ready  target, physical_address, ram_write_data
//
// one access at a time: it is latched, its result is loaded in ST_OUT once the result
// register is free, then the next access can be taken; switchable rom reads first wait in
// ST_DIV, where the 7-step restoring remainder unit wraps the bank one bit per cycle
// the result register frees the input side, so a new access is taken while a result waits
// reset (rst_ni low) is asynchronous and restores bank counts and banking registers
// cfg_i always ready; user must send writes only with no access in flight (unchecked)
module rom_ram_bank_mapper (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrbm_cfg_if.sink   cfg_i,
  rrbm_in_if.sink    in_i,
  rrbm_out_if.source out_o
);

  rrbm_pkg::dp_cmd_t cmd;
  rrbm_pkg::dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rrbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrbm_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .cfg_valid_i            (cfg_i.valid),
    .cfg_index_i            (cfg_i.index),
    .cfg_data_i             (cfg_i.data),
    .in_operation_i         (in_i.operation),
    .in_bus_address_i       (in_i.bus_address),
    .in_write_byte_i        (in_i.write_byte),
    .out_ready_i            (out_o.ready),
    .out_valid_o            (out_o.valid),
    .out_target_o           (out_o.target),
    .out_physical_address_o (out_o.physical_address),
    .out_ram_write_data_o   (out_o.ram_write_data)
  );

  // the remainder unit is never running while a new word can be taken
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !sts.div_busy)
    else $error("remainder unit busy while accepting");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second access taken while one is in flight");

  // ram offsets stay inside four 8 KiB banks
  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.target == 3'(rrbm_pkg::TGT_RAM_READ) ||
                     out_o.target == 3'(rrbm_pkg::TGT_RAM_WRITE)))
      |-> (out_o.physical_address[20:15] == '0))
    else $error("ram offset beyond four banks");

  a_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.target == 3'(rrbm_pkg::TGT_OPEN_BUS) ||
                     out_o.target == 3'(rrbm_pkg::TGT_REG_WRITE) ||
                     out_o.target == 3'(rrbm_pkg::TGT_UNMAPPED)))
      |-> (out_o.physical_address == '0 && out_o.ram_write_data == '0))
    else $error("address or data on a word without memory access");

endmodule

/* tb/rom_ram_bank_mapper_test.sv */
// rom_ram_bank_mapper_test: self-checking random and directed testbench of the bank mapper
`timescale 1ns / 1ps

module rom_ram_bank_mapper_test;

  localparam logic [rrbm_pkg::OpW-1:0] OP_READ  = 1'b0;
  localparam logic [rrbm_pkg::OpW-1:0] OP_WRITE = 1'b1;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;

  localparam int unsigned ITEMS_PER_PHASE = 153;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [rrbm_pkg::OpW-1:0]   op;
    logic [rrbm_pkg::AddrW-1:0] addr;
    logic [rrbm_pkg::ByteW-1:0] wbyte;
  } access_t;

  typedef struct packed {
    rrbm_pkg::target_e          tgt;
    logic [rrbm_pkg::PhysW-1:0] phys;
    logic [rrbm_pkg::ByteW-1:0] wdata;
  } mapping_t;

  logic clk_i;
  logic rst_ni;

  rrbm_in_if  acc_bus ();
  rrbm_out_if map_bus ();
  rrbm_cfg_if cfg_bus ();

  rom_ram_bank_mapper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (acc_bus),
    .out_o  (map_bus)
  );

  // predictor copy of the bank counts and banking registers
  int unsigned    rom_cnt;
  int unsigned    ram_cnt;
  logic           ram_on;
  logic [4:0]     bank_lo;
  logic [1:0]     bank_hi;
  logic           ram_mode;

  access_t        pending_accesses[$];
  mapping_t       expected_maps[$];
  int unsigned    fault_count;
  bit             no_idle;
  int unsigned    gap_left;
  int unsigned    stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // expected mapping of one access, updating the banking registers on register writes
  function automatic mapping_t map_access(access_t a);
    mapping_t    m;
    logic [6:0]  bank;
    int unsigned divisor;
    int unsigned ram_b;
    int unsigned off;
    m.tgt   = rrbm_pkg::TGT_UNMAPPED;
    m.phys  = '0;
    m.wdata = '0;
    if (a.addr >= 16'hA000 && a.addr <= 16'hBFFF) begin
      ram_b = (ram_mode && ram_cnt > 1) ? bank_hi : 0;
      off   = a.addr - 16'hA000;
      if (!ram_on) begin
        m.tgt = (a.op == OP_WRITE) ? rrbm_pkg::TGT_REG_WRITE : rrbm_pkg::TGT_OPEN_BUS;
      end else if (a.op == OP_WRITE) begin
        m.tgt   = rrbm_pkg::TGT_RAM_WRITE;
        m.phys  = rrbm_pkg::PhysW'(off + ram_b * RAM_BANK_BYTES);
        m.wdata = a.wbyte;
      end else begin
        m.tgt  = rrbm_pkg::TGT_RAM_READ;
        m.phys = rrbm_pkg::PhysW'(off + ram_b * RAM_BANK_BYTES);
      end
    end else if (a.addr[15]) begin
      m.tgt = rrbm_pkg::TGT_UNMAPPED;
    end else if (a.op == OP_WRITE) begin
      m.tgt = rrbm_pkg::TGT_REG_WRITE;
      case (rrbm_pkg::reg_win_e'(a.addr[14:13]))
        rrbm_pkg::WIN_RAM_ENABLE: ram_on  = (a.wbyte[3:0] == rrbm_pkg::RamEnableKey);
        rrbm_pkg::WIN_BANK_LOW:   bank_lo = a.wbyte[4:0];
        rrbm_pkg::WIN_BANK_HIGH:  bank_hi = a.wbyte[1:0];
        default: begin
          if (a.wbyte == rrbm_pkg::ModeRomByte) ram_mode = 1'b0;
          else if (a.wbyte == rrbm_pkg::ModeRamByte) ram_mode = 1'b1;
        end
      endcase
    end else begin
      m.tgt = rrbm_pkg::TGT_ROM_READ;
      if (!a.addr[14]) begin
        m.phys = rrbm_pkg::PhysW'(a.addr);
      end else begin
        bank = ram_mode ? {2'b00, bank_lo} : {bank_hi, bank_lo};
        // banks with a zero low field never select themselves
        if (bank[4:0] == 5'd0) bank = bank + 7'd1;
        divisor = (rom_cnt == 0) ? 1 : rom_cnt;
        m.phys  = rrbm_pkg::PhysW'((bank % divisor) * ROM_BANK_BYTES + a.addr[13:0]);
      end
    end
    return m;
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    a.op    = rrbm_pkg::OpW'($urandom_range(0, 1));
    a.addr  = rrbm_pkg::AddrW'($urandom_range(0, 16'hFFFF));
    a.wbyte = rrbm_pkg::ByteW'($urandom_range(0, 255));
    pick    = $urandom_range(0, 99);
    if (pick < 10) begin
      // fully random word
    end else if (pick < 20) begin
      a.op    = OP_WRITE;
      a.addr  = rrbm_pkg::AddrW'($urandom_range(16'h0000, 16'h1FFF));
      a.wbyte[3:0] = ($urandom_range(0, 9) < 7) ? rrbm_pkg::RamEnableKey
                                                : 4'($urandom_range(0, 15));
    end else if (pick < 28) begin
      a.op   = OP_WRITE;
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'h2000, 16'h3FFF));
      if ($urandom_range(0, 3) == 0) a.wbyte[4:0] = 5'd0;
    end else if (pick < 34) begin
      a.op   = OP_WRITE;
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'h4000, 16'h5FFF));
    end else if (pick < 40) begin
      a.op   = OP_WRITE;
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'h6000, 16'h7FFF));
      pick   = $urandom_range(0, 9);
      if (pick < 4) a.wbyte = rrbm_pkg::ModeRomByte;
      else if (pick < 8) a.wbyte = rrbm_pkg::ModeRamByte;
    end else if (pick < 60) begin
      a.op   = OP_READ;
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'h4000, 16'h7FFF));
    end else if (pick < 68) begin
      a.op   = OP_READ;
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'h0000, 16'h3FFF));
    end else if (pick < 92) begin
      a.addr = rrbm_pkg::AddrW'($urandom_range(16'hA000, 16'hBFFF));
    end else begin
      a.addr = rrbm_pkg::AddrW'($urandom_range(0, 1) ? $urandom_range(16'h8000, 16'h9FFF)
                                                     : $urandom_range(16'hC000, 16'hFFFF));
    end
    return a;
  endfunction

  task automatic add_access(logic [rrbm_pkg::OpW-1:0] op, logic [rrbm_pkg::AddrW-1:0] addr,
                            logic [rrbm_pkg::ByteW-1:0] wbyte);
    access_t a;
    a.op    = op;
    a.addr  = addr;
    a.wbyte = wbyte;
    pending_accesses.push_back(a);
  endtask

  task automatic write_reg(rrbm_pkg::cfg_reg_e idx, logic [rrbm_pkg::CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == rrbm_pkg::REG_ROM_BANK_COUNT) rom_cnt = val[rrbm_pkg::RomCountW-1:0];
    else if (idx == rrbm_pkg::REG_RAM_BANK_COUNT) ram_cnt = val[rrbm_pkg::RamCountW-1:0];
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() != 0 || expected_maps.size() != 0 || acc_bus.valid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // access driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (acc_bus.valid && acc_bus.ready)
        expected_maps.push_back(map_access({acc_bus.operation, acc_bus.bus_address,
                                            acc_bus.write_byte}));
      if (!acc_bus.valid || acc_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          acc_bus.valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          access_t a;
          a = pending_accesses.pop_front();
          acc_bus.valid       <= 1'b1;
          acc_bus.operation   <= a.op;
          acc_bus.bus_address <= a.addr;
          acc_bus.write_byte  <= a.wbyte;
          gap_left = pick_gap();
        end else begin
          acc_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (map_bus.valid && map_bus.ready) begin
        if (expected_maps.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected word: target %0d phys 0x%06h data 0x%02h",
                     map_bus.target, map_bus.physical_address, map_bus.ram_write_data);
        end else begin
          mapping_t e;
          e = expected_maps.pop_front();
          if (map_bus.target !== e.tgt || map_bus.physical_address !== e.phys ||
              map_bus.ram_write_data !== e.wdata) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display({"mismatch: expected target %0d phys 0x%06h data 0x%02h,",
                        " got %0d 0x%06h 0x%02h"},
                       e.tgt, e.phys, e.wdata, map_bus.target, map_bus.physical_address,
                       map_bus.ram_write_data);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        map_bus.ready <= 1'b0;
      end else begin
        map_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((acc_bus.valid && acc_bus.ready) || (map_bus.valid && map_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned rom_setting[9];
    int unsigned ram_setting[9];
    rom_setting = '{1, 128, 0, 200, 2, 5, 64, 37, 0};
    ram_setting = '{1, 4, 0, 7, 2, 3, 4, 4, 0};

    rst_ni                = 1'b0;
    acc_bus.valid         = 1'b0;
    acc_bus.operation     = OP_READ;
    acc_bus.bus_address   = '0;
    acc_bus.write_byte    = '0;
    map_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = rrbm_pkg::REG_ROM_BANK_COUNT;
    cfg_bus.data          = '0;
    fault_count           = 0;
    no_idle               = 1'b0;
    rom_cnt               = rrbm_pkg::RomCountReset;
    ram_cnt               = rrbm_pkg::RamCountReset;
    ram_on                = 1'b0;
    bank_lo               = rrbm_pkg::BankLowReset;
    bank_hi               = 2'd0;
    ram_mode              = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window edges, disabled ram, unmapped space, bank bumps, mode bytes
    add_access(OP_READ,  16'h0000, 8'h00);
    add_access(OP_READ,  16'h3FFF, 8'hFF);
    add_access(OP_READ,  16'h4000, 8'h00);
    add_access(OP_READ,  16'h7FFF, 8'h00);
    add_access(OP_READ,  16'hA000, 8'h00);
    add_access(OP_WRITE, 16'hBFFF, 8'hFF);
    add_access(OP_READ,  16'h8000, 8'h00);
    add_access(OP_WRITE, 16'h9FFF, 8'h55);
    add_access(OP_READ,  16'hFFFF, 8'hFF);
    add_access(OP_WRITE, 16'hC000, 8'hFF);
    add_access(OP_WRITE, 16'h0000, 8'hFA);
    add_access(OP_WRITE, 16'hA000, 8'hFF);
    add_access(OP_READ,  16'hBFFF, 8'h00);
    add_access(OP_WRITE, 16'h2000, 8'h00);
    add_access(OP_READ,  16'h4000, 8'h00);
    add_access(OP_WRITE, 16'h5FFF, 8'hFF);
    add_access(OP_WRITE, 16'h3FFF, 8'hE0);
    add_access(OP_READ,  16'h7FFF, 8'h00);
    add_access(OP_WRITE, 16'h6000, 8'h02);
    add_access(OP_WRITE, 16'h7FFF, rrbm_pkg::ModeRamByte);
    add_access(OP_READ,  16'h5555, 8'h00);
    add_access(OP_WRITE, 16'hB000, 8'h5A);
    add_access(OP_WRITE, 16'h6000, rrbm_pkg::ModeRomByte);
    add_access(OP_WRITE, 16'h1FFF, 8'h0B);
    add_access(OP_READ,  16'hA123, 8'h00);
    repeat (ITEMS_PER_PHASE) pending_accesses.push_back(random_access());
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      if (p == 8) begin
        rom_setting[p] = $urandom_range(1, 128);
        ram_setting[p] = $urandom_range(1, 4);
      end
      write_reg(rrbm_pkg::REG_ROM_BANK_COUNT, rrbm_pkg::CfgDataW'(rom_setting[p]));
      write_reg(rrbm_pkg::REG_RAM_BANK_COUNT, rrbm_pkg::CfgDataW'(ram_setting[p]));
      no_idle = (p % 4 == 2);
      repeat (ITEMS_PER_PHASE) pending_accesses.push_back(random_access());
      wait_idle();
    end

    if (fault_count == 0 && expected_maps.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
